/* design/assert_macros.svh */
// assertion macros shared by the rtl files
// each macro clocks on i_clk and is disabled while i_rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge out of reset
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// implication form, consequent checked in the same cycle
`define ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

/* design/cbo_pkg.sv */
// package for the checkerboard brightness overlay
// holds register indices, field widths and the saturating channel add; no dependencies
`default_nettype none

package cbo_pkg;

    localparam int MAX_SIDE_DEF = 4096;
    localparam int CH_W         = 8;
    localparam int OFFSET_W     = 9;
    localparam int GEOM_W       = 13;
    localparam int CFG_IDX_W    = 3;
    localparam int PIX_W        = 3 * CH_W;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_OFFSET = 3'd0,
        CFG_CELL   = 3'd1,
        CFG_WIDTH  = 3'd2,
        CFG_HEIGHT = 3'd3
    } t_cfg_idx;

    // channel plus signed offset, clamped to 0..255
    function automatic logic [CH_W-1:0] sat_add(input logic [CH_W-1:0] ch,
                                                input logic signed [OFFSET_W-1:0] off);
        logic signed [CH_W+1:0] sum;
        sum = $signed({2'b00, ch}) + CH_W'(0) + off;
        if (sum < 0) begin
            sat_add = '0;
        end else if (sum > $signed(10'sd255)) begin
            sat_add = '1;
        end else begin
            sat_add = sum[CH_W-1:0];
        end
    endfunction

endpackage

`default_nettype wire

/* design/checkerboard_brightness_overlay_core.sv */
// Checkerboard brightness overlay: one RGB pixel per clock in raster order, top row first,
// unless a divide run or a downstream stall holds tready low. A pixel can be taken in the
// same cycle its predecessor's result is taken downstream, and its result is loaded into
// the output register, which holds it while the downstream side stalls. After a write of
// cell_size, image_width or image_height the frame restarts at the top-left pixel and the
// input holds tready low while a one-bit-per-cycle restoring divider finds (height-1) mod
// cell and the parity of (height-1) div cell, which set the bottom-origin row phase of the
// top row. Offset writes take effect at once.
// Config writes are always taken (o_cfg_ready is tied high).
// Depends on cbo_pkg and assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

module checkerboard_brightness_overlay_core #(
    parameter int MAX_SIDE = cbo_pkg::MAX_SIDE_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    // pixel in
    input  wire logic                             i_s_tvalid,
    output logic                                  o_s_tready,
    input  wire logic [cbo_pkg::PIX_W-1:0]        i_s_tdata,   // red_in, green_in, blue_in
    // pixel out
    output logic                                  o_m_tvalid,
    input  wire logic                             i_m_tready,
    output logic [cbo_pkg::PIX_W-1:0]             o_m_tdata,   // red_out, green_out, blue_out
    output logic [1:0]                            o_m_tuser,   // in_even_cell, row_end
    output logic                                  o_m_tlast,   // frame_end
    // register writes
    input  wire logic                             i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire logic [cbo_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [cbo_pkg::GEOM_W-1:0]       i_cfg_data
);

    localparam int GEOM_MAX = (1 << cbo_pkg::GEOM_W) - 1;
    localparam int MAXEFF   = (MAX_SIDE < GEOM_MAX) ? MAX_SIDE : GEOM_MAX;
    localparam int EW       = $clog2(MAXEFF + 1);   // effective side width
    localparam int PW       = $clog2(MAXEFF);       // counter / phase width
    localparam int CW       = $clog2(PW);           // divider step counter width
    localparam int CH_W     = cbo_pkg::CH_W;

    // configuration: the offset, and the sides stored as effective side minus one
    logic signed [cbo_pkg::OFFSET_W-1:0] r_offset, n_offset;
    logic [PW-1:0] r_cm1, n_cm1;
    logic [PW-1:0] r_wm1, n_wm1;
    logic [PW-1:0] r_hm1, n_hm1;

    // frame position
    logic [PW-1:0] r_col_cnt, n_col_cnt;
    logic [PW-1:0] r_row_cnt, n_row_cnt;
    logic [PW-1:0] r_col_ph, n_col_ph;
    logic [PW-1:0] r_row_ph, n_row_ph;
    logic          r_col_par, n_col_par;
    logic          r_row_par, n_row_par;

    // top-row start values, from the divider
    logic [PW-1:0] r_start_ph, n_start_ph;
    logic          r_start_par, n_start_par;

    // divider
    logic          r_div_busy, n_div_busy;
    logic [CW-1:0] r_div_cnt, n_div_cnt;
    logic [EW-1:0] r_rem, n_rem;

    // output register
    logic                        r_m_valid, n_m_valid;
    logic [cbo_pkg::PIX_W-1:0]   r_m_data, n_m_data;
    logic [1:0]                  r_m_user, n_m_user;
    logic                        r_m_last, n_m_last;

    logic          s_accept;
    logic          cfg_wr;
    logic          geom_wr;
    logic [PW-1:0] geom_m1;
    logic [EW-1:0] cell_eff;
    logic [EW:0]   rem_sh;
    logic          rem_ge;
    logic [EW:0]   rem_sub;
    logic          even;
    logic          last_col;
    logic          last_row;

    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid;
    assign o_s_tready  = !r_div_busy && (!r_m_valid || i_m_tready);
    assign s_accept    = i_s_tvalid && o_s_tready;

    // zero acts as one, oversize as the maximum side
    always_comb begin
        if (i_cfg_data == '0) begin
            geom_m1 = '0;
        end else if (i_cfg_data > cbo_pkg::GEOM_W'(MAXEFF)) begin
            geom_m1 = PW'(MAXEFF - 1);
        end else begin
            geom_m1 = PW'(i_cfg_data - 1'b1);
        end
    end

    assign geom_wr = cfg_wr && (i_cfg_index == cbo_pkg::CFG_CELL
                             || i_cfg_index == cbo_pkg::CFG_WIDTH
                             || i_cfg_index == cbo_pkg::CFG_HEIGHT);

    // restoring divide step, one quotient bit a cycle, msb first
    assign cell_eff = EW'(r_cm1) + 1'b1;
    assign rem_sh   = {r_rem, r_hm1[CW'(PW - 1) - r_div_cnt]};
    assign rem_ge   = rem_sh >= {1'b0, cell_eff};
    assign rem_sub  = rem_sh - {1'b0, cell_eff};

    assign even     = !(r_row_par ^ r_col_par);
    assign last_col = r_col_cnt >= r_wm1;
    assign last_row = r_row_cnt >= r_hm1;

    always_comb begin
        n_offset    = r_offset;
        n_cm1       = r_cm1;
        n_wm1       = r_wm1;
        n_hm1       = r_hm1;
        n_col_cnt   = r_col_cnt;
        n_row_cnt   = r_row_cnt;
        n_col_ph    = r_col_ph;
        n_row_ph    = r_row_ph;
        n_col_par   = r_col_par;
        n_row_par   = r_row_par;
        n_start_ph  = r_start_ph;
        n_start_par = r_start_par;
        n_div_busy  = r_div_busy;
        n_div_cnt   = r_div_cnt;
        n_rem       = r_rem;
        n_m_valid   = r_m_valid;
        n_m_data    = r_m_data;
        n_m_user    = r_m_user;
        n_m_last    = r_m_last;

        // output register
        if (s_accept) begin
            n_m_valid = 1'b1;
            n_m_data  = i_s_tdata;
            if (even) begin
                n_m_data = {cbo_pkg::sat_add(i_s_tdata[3*CH_W-1:2*CH_W], r_offset),
                            cbo_pkg::sat_add(i_s_tdata[2*CH_W-1:CH_W], r_offset),
                            cbo_pkg::sat_add(i_s_tdata[CH_W-1:0], r_offset)};
            end
            n_m_user = {last_col, even};
            n_m_last = last_col && last_row;
        end else if (i_m_tready) begin
            n_m_valid = 1'b0;
        end

        // frame position
        if (s_accept) begin
            if (!last_col) begin
                n_col_cnt = r_col_cnt + 1'b1;
                if (r_col_ph >= r_cm1) begin
                    n_col_ph  = '0;
                    n_col_par = !r_col_par;
                end else begin
                    n_col_ph = r_col_ph + 1'b1;
                end
            end else begin
                n_col_cnt = '0;
                n_col_ph  = '0;
                n_col_par = 1'b0;
                if (last_row) begin
                    n_row_cnt = '0;
                    n_row_ph  = r_start_ph;
                    n_row_par = r_start_par;
                end else begin
                    n_row_cnt = r_row_cnt + 1'b1;
                    if (r_row_ph == '0) begin
                        n_row_ph  = r_cm1;
                        n_row_par = !r_row_par;
                    end else begin
                        n_row_ph = r_row_ph - 1'b1;
                    end
                end
            end
        end

        // divider run
        if (r_div_busy) begin
            n_rem     = rem_ge ? EW'(rem_sub) : EW'(rem_sh);
            n_div_cnt = r_div_cnt + 1'b1;
            if (r_div_cnt == CW'(PW - 1)) begin
                n_div_busy  = 1'b0;
                n_start_ph  = PW'(n_rem);
                n_start_par = rem_ge;
                n_row_ph    = PW'(n_rem);
                n_row_par   = rem_ge;
            end
        end

        // register writes, geometry restarts the frame and the divider
        if (cfg_wr) begin
            case (i_cfg_index)
                cbo_pkg::CFG_OFFSET: n_offset = $signed(i_cfg_data[cbo_pkg::OFFSET_W-1:0]);
                cbo_pkg::CFG_CELL:   n_cm1 = geom_m1;
                cbo_pkg::CFG_WIDTH:  n_wm1 = geom_m1;
                cbo_pkg::CFG_HEIGHT: n_hm1 = geom_m1;
                default: ;
            endcase
        end
        if (geom_wr) begin
            n_col_cnt  = '0;
            n_row_cnt  = '0;
            n_col_ph   = '0;
            n_col_par  = 1'b0;
            n_div_busy = 1'b1;
            n_div_cnt  = '0;
            n_rem      = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset    <= '0;
            r_cm1       <= '0;
            r_wm1       <= '0;
            r_hm1       <= '0;
            r_col_cnt   <= '0;
            r_row_cnt   <= '0;
            r_col_ph    <= '0;
            r_row_ph    <= '0;
            r_col_par   <= 1'b0;
            r_row_par   <= 1'b0;
            r_start_ph  <= '0;
            r_start_par <= 1'b0;
            r_div_busy  <= 1'b0;
            r_div_cnt   <= '0;
            r_rem       <= '0;
            r_m_valid   <= 1'b0;
        end else begin
            r_offset    <= n_offset;
            r_cm1       <= n_cm1;
            r_wm1       <= n_wm1;
            r_hm1       <= n_hm1;
            r_col_cnt   <= n_col_cnt;
            r_row_cnt   <= n_row_cnt;
            r_col_ph    <= n_col_ph;
            r_row_ph    <= n_row_ph;
            r_col_par   <= n_col_par;
            r_row_par   <= n_row_par;
            r_start_ph  <= n_start_ph;
            r_start_par <= n_start_par;
            r_div_busy  <= n_div_busy;
            r_div_cnt   <= n_div_cnt;
            r_rem       <= n_rem;
            r_m_valid   <= n_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_m_data <= n_m_data;
        r_m_user <= n_m_user;
        r_m_last <= n_m_last;
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_data;
    assign o_m_tuser  = r_m_user;
    assign o_m_tlast  = r_m_last;

    `ASSERT_IMP(a_no_take_while_div, r_div_busy, !o_s_tready, "pixel taken during divide")
    `ASSERT_IMP(a_row_ph_in_cell, !r_div_busy, r_row_ph <= r_cm1, "row phase beyond cell")
    `ASSERT_CLK(a_col_ph_in_cell, r_col_ph <= r_cm1, "column phase beyond cell")
    `ASSERT_IMP(a_frame_end_row_end, r_m_valid && r_m_last, r_m_user[1],
                "frame end without row end")
    `ASSERT_IMP(a_div_done_at_top, $fell(r_div_busy), r_row_cnt == '0 && r_col_cnt == '0,
                "divide finished away from the top-left pixel")

endmodule

`default_nettype wire

/* tb/sv/cbo_overlay_checker.sv */
// pixel checker for the checkerboard brightness overlay core: follows the register writes,
// predicts each accepted pixel and compares it with the result words; depends on cbo_pkg
module cbo_overlay_checker
    import cbo_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_s_tvalid,
    input  wire logic                 i_s_tready,
    input  wire logic [PIX_W-1:0]     i_s_tdata,   // red_in, green_in, blue_in
    input  wire logic                 i_m_tvalid,
    input  wire logic                 i_m_tready,
    input  wire logic [PIX_W-1:0]     i_m_tdata,   // red_out, green_out, blue_out
    input  wire logic [1:0]           i_m_tuser,   // in_even_cell, row_end
    input  wire logic                 i_m_tlast,   // frame_end
    input  wire logic                 i_cfg_valid,
    input  wire logic                 i_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [GEOM_W-1:0]    i_cfg_data,
    output int                        o_pending,
    output int                        o_fail_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
        logic            even_cell;
        logic            row_end;
        logic            frame_end;
    } t_overlay_pixel;

    logic signed [OFFSET_W-1:0] offset_reg;
    logic [GEOM_W-1:0]          cell_reg;
    logic [GEOM_W-1:0]          width_reg;
    logic [GEOM_W-1:0]          height_reg;

    int unsigned col_count;
    int unsigned row_count;
    int unsigned col_phase;
    int unsigned row_phase;
    bit          col_parity;
    bit          row_parity;

    t_overlay_pixel overlay_q[$];

    // geometry codes of 0 act as 1, oversize codes act as the largest side
    function automatic int unsigned geom_side(input logic [GEOM_W-1:0] code);
        if (code == '0) return 1;
        if (code > MAX_SIDE_DEF) return MAX_SIDE_DEF;
        return 32'(code);
    endfunction

    function automatic logic [CH_W-1:0] offset_channel(input logic [CH_W-1:0] ch,
                                                       input logic signed [OFFSET_W-1:0] off);
        int sum;
        sum = int'(ch) + int'(off);
        if (sum < 0) return '0;
        if (sum > 255) return '1;
        return sum[CH_W-1:0];
    endfunction

    // rows are counted from the bottom, so the top row starts part way into a cell
    task automatic load_top_row();
        int unsigned c;
        int unsigned top;
        c = geom_side(cell_reg);
        top = geom_side(height_reg) - 1;
        row_phase = top % c;
        row_parity = ((top / c) % 2) != 0;
    endtask

    task automatic restart_frame();
        col_count = 0;
        row_count = 0;
        col_phase = 0;
        col_parity = 1'b0;
        load_top_row();
    endtask

    task automatic apply_reg_write(input logic [CFG_IDX_W-1:0] idx,
                                   input logic [GEOM_W-1:0] data);
        case (idx)
            CFG_OFFSET: offset_reg = data[OFFSET_W-1:0];
            CFG_CELL: begin
                cell_reg = data;
                restart_frame();
            end
            CFG_WIDTH: begin
                width_reg = data;
                restart_frame();
            end
            CFG_HEIGHT: begin
                height_reg = data;
                restart_frame();
            end
            default: ;
        endcase
    endtask

    task automatic predict_pixel(input logic [PIX_W-1:0] pix, output t_overlay_pixel res);
        int unsigned c;
        int unsigned w;
        int unsigned h;
        bit          even;
        bit          last_col;
        bit          last_row;
        c = geom_side(cell_reg);
        w = geom_side(width_reg);
        h = geom_side(height_reg);
        even = (row_parity ^ col_parity) == 1'b0;
        last_col = col_count >= w - 1;
        last_row = row_count >= h - 1;

        res.red       = even ? offset_channel(pix[7:0], offset_reg) : pix[7:0];
        res.green     = even ? offset_channel(pix[15:8], offset_reg) : pix[15:8];
        res.blue      = even ? offset_channel(pix[23:16], offset_reg) : pix[23:16];
        res.even_cell = even;
        res.row_end   = last_col;
        res.frame_end = last_col && last_row;

        if (!last_col) begin
            col_count++;
            if (col_phase >= c - 1) begin
                col_phase = 0;
                col_parity = ~col_parity;
            end else begin
                col_phase++;
            end
        end else begin
            col_count = 0;
            col_phase = 0;
            col_parity = 1'b0;
            if (last_row) begin
                row_count = 0;
                load_top_row();
            end else begin
                row_count++;
                if (row_phase == 0) begin
                    row_phase = c - 1;
                    row_parity = ~row_parity;
                end else begin
                    row_phase--;
                end
            end
        end
    endtask

    task automatic check_field(input string what, input int want, input int got);
        if (want != got) begin
            o_fail_count++;
            $display("@%0t ns: %s mismatch, expected %0d, got %0d", $time, what, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        t_overlay_pixel want;
        t_overlay_pixel got;
        if (!i_rst_n) begin
            offset_reg = '0;
            cell_reg = GEOM_W'(1);
            width_reg = GEOM_W'(1);
            height_reg = GEOM_W'(1);
            restart_frame();
            overlay_q.delete();
        end else begin
            // a result word always belongs to an earlier pixel, so retire before predicting
            if (i_m_tvalid && i_m_tready) begin
                got.red       = i_m_tdata[7:0];
                got.green     = i_m_tdata[15:8];
                got.blue      = i_m_tdata[23:16];
                got.even_cell = i_m_tuser[0];
                got.row_end   = i_m_tuser[1];
                got.frame_end = i_m_tlast;
                if (overlay_q.size() == 0) begin
                    o_fail_count++;
                    $display("@%0t ns: unexpected word, expected none, got %h",
                             $time, got);
                end else begin
                    want = overlay_q.pop_front();
                    check_field("red", int'(want.red), int'(got.red));
                    check_field("green", int'(want.green), int'(got.green));
                    check_field("blue", int'(want.blue), int'(got.blue));
                    check_field("in_even_cell", int'(want.even_cell), int'(got.even_cell));
                    check_field("row_end", int'(want.row_end), int'(got.row_end));
                    check_field("frame_end", int'(want.frame_end), int'(got.frame_end));
                end
            end
            if (i_cfg_valid && i_cfg_ready)
                apply_reg_write(i_cfg_index, i_cfg_data);
            if (i_s_tvalid && i_s_tready) begin
                predict_pixel(i_s_tdata, want);
                overlay_q.push_back(want);
            end
        end
        o_pending = overlay_q.size();
    end

endmodule

/* tb/sv/tb_checkerboard_brightness_overlay_core.sv */
// top of the checkerboard brightness overlay testbench: clock, reset, pixel and register
// stimulus with random gaps and stalls; depends on cbo_pkg, the core and cbo_overlay_checker
module tb_checkerboard_brightness_overlay_core;
    timeunit 1ns;
    timeprecision 1ps;
    import cbo_pkg::*;

    localparam int ITEM_TARGET = 1950;
    localparam logic [CFG_IDX_W-1:0] FIRST_SPARE_IDX = CFG_IDX_W'(CFG_HEIGHT + 1);

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic [PIX_W-1:0]     s_tdata = '0;
    logic                 m_tready = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_OFFSET;
    logic [GEOM_W-1:0]    cfg_data = '0;

    wire logic             s_tready;
    wire logic             m_tvalid;
    wire logic [PIX_W-1:0] m_tdata;
    wire logic [1:0]       m_tuser;
    wire logic             m_tlast;
    wire logic             cfg_ready;

    int pending;
    int fail_count;
    int pixels_sent = 0;
    int hold = 0;
    bit steady = 1'b0;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    checkerboard_brightness_overlay_core dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata),
        .o_m_tuser   (m_tuser),
        .o_m_tlast   (m_tlast),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    cbo_overlay_checker overlay_chk (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tuser    (m_tuser),
        .i_m_tlast    (m_tlast),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    // result side: after each word taken, drop m_tready for a random stall unless steady is set
    always @(posedge clk) begin
        int stall;
        if (!rst_n) begin
            m_tready <= 1'b0;
            hold <= 0;
        end else if (m_tready) begin
            if (m_tvalid) begin
                stall = steady ? 0 : $urandom_range(0, 3);
                if (stall != 0) begin
                    m_tready <= 1'b0;
                    hold <= stall - 1;
                end
            end
        end else if (hold != 0) begin
            hold <= hold - 1;
        end else begin
            m_tready <= 1'b1;
        end
    end

    task automatic push_pixel(input logic [PIX_W-1:0] pix);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 3);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= pix;
        do @(posedge clk); while (!s_tready);
        pixels_sent++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [GEOM_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // stop sending and let every outstanding pixel drain before touching registers
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        do @(negedge clk); while (pending != 0);
        repeat (2) @(posedge clk);
    endtask

    function automatic logic [CH_W-1:0] rand_channel();
        case ($urandom_range(0, 4))
            0: return '0;
            1: return '1;
            default: return CH_W'($urandom_range(0, 255));
        endcase
    endfunction

    // mostly small sides, now and then zero, the largest, or an oversize code
    function automatic logic [GEOM_W-1:0] rand_side(input int usual_max);
        case ($urandom_range(0, 19))
            0: return '0;
            1: return GEOM_W'($urandom_range(MAX_SIDE_DEF + 1, (1 << GEOM_W) - 1));
            2: return GEOM_W'(MAX_SIDE_DEF);
            default: return GEOM_W'($urandom_range(1, usual_max));
        endcase
    endfunction

    initial begin
        logic [PIX_W-1:0] corner_px [9];
        int               n;
        logic [GEOM_W-1:0] off_code;
        corner_px = '{24'h000000, 24'hFFFFFF, 24'h01FF80, 24'hFE0100, 24'h7F8081,
                      24'h00FF00, 24'hFF00FF, 24'h123456, 24'hFFFF00};

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // default geometry is a single-pixel frame with no offset
        push_pixel(24'h000000);

        // full positive offset on a 3x3 frame with 2-pixel cells
        wait_idle();
        write_reg(CFG_OFFSET, 13'h00FF);
        write_reg(CFG_CELL, 13'd2);
        write_reg(CFG_WIDTH, 13'd3);
        write_reg(CFG_HEIGHT, 13'd3);
        foreach (corner_px[i]) push_pixel(corner_px[i]);

        // most negative code drives even cells to black
        wait_idle();
        write_reg(CFG_OFFSET, 13'h0100);
        repeat (3) push_pixel(24'hFFFFFF);

        // -255 with junk in the unused upper data bits
        wait_idle();
        write_reg(CFG_OFFSET, 13'h1F01);
        push_pixel(24'h80FF01);
        push_pixel(24'h0000FE);

        // zero geometry behaves as 1
        wait_idle();
        write_reg(CFG_CELL, 13'd0);
        write_reg(CFG_WIDTH, 13'd0);
        write_reg(CFG_HEIGHT, 13'd0);
        write_reg(CFG_OFFSET, 13'h0001);
        push_pixel(24'hFF00FF);
        push_pixel(24'h7F7F7F);

        // oversize codes, cell bigger than the image
        wait_idle();
        write_reg(CFG_CELL, 13'h1FFF);
        write_reg(CFG_WIDTH, 13'd2);
        write_reg(CFG_HEIGHT, 13'h1FFF);
        repeat (3) push_pixel({rand_channel(), rand_channel(), rand_channel()});

        // write to an unused index must change nothing
        wait_idle();
        write_reg(FIRST_SPARE_IDX, 13'h1FFF);
        push_pixel(24'h408020);

        while (pixels_sent < ITEM_TARGET) begin
            wait_idle();
            steady = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 1) == 1) begin
                case ($urandom_range(0, 7))
                    0: off_code = 13'h00FF;
                    1: off_code = 13'h0101;
                    2: off_code = 13'h0100;
                    3: off_code = 13'h0000;
                    default: off_code = GEOM_W'($urandom_range(0, (1 << GEOM_W) - 1));
                endcase
                write_reg(CFG_OFFSET, off_code);
            end
            if ($urandom_range(0, 2) == 0) write_reg(CFG_CELL, rand_side(4));
            if ($urandom_range(0, 2) == 0) write_reg(CFG_WIDTH, rand_side(7));
            if ($urandom_range(0, 2) == 0) write_reg(CFG_HEIGHT, rand_side(6));
            if ($urandom_range(0, 7) == 0)
                write_reg(CFG_IDX_W'($urandom_range(FIRST_SPARE_IDX, (1 << CFG_IDX_W) - 1)),
                          GEOM_W'($urandom_range(0, (1 << GEOM_W) - 1)));
            n = $urandom_range(1, 80);
            repeat (n) push_pixel({rand_channel(), rand_channel(), rand_channel()});
        end

        wait_idle();
        repeat (4) @(posedge clk);
        @(negedge clk);
        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("FAIL");
        $finish;
    end

endmodule

/* files.f */
+incdir+design
design/cbo_pkg.sv
design/checkerboard_brightness_overlay_core.sv
tb/sv/cbo_overlay_checker.sv
tb/sv/tb_checkerboard_brightness_overlay_core.sv
